@@ src/bfa_pkg.sv @@
// ----------------------------------------------------------------------------
// bfa_pkg
// Shared types and constants of the best-fit block allocator.
// ----------------------------------------------------------------------------
`default_nettype none
package bfa_pkg;

  localparam int unsigned MaxBlocksDefault   = 64;
  localparam int unsigned HeaderBytesDefault = 32;

  localparam logic [2:0] StOk      = 3'd0;
  localparam logic [2:0] StZero    = 3'd1;
  localparam logic [2:0] StNoSpace = 3'd2;
  localparam logic [2:0] StNull    = 3'd3;
  localparam logic [2:0] StUnknown = 3'd4;

  localparam logic OpAlloc = 1'b0;
  localparam logic OpFree  = 1'b1;

  localparam logic [31:0] HeapLimitReset = 32'hFFFF_FFFF;

  // one entry of the block table: header start, data size, free mark
  typedef struct packed {
    logic [31:0] start;
    logic [31:0] size;
    logic        free;
  } entry_t;

  typedef struct packed {
    logic        opcode;
    logic [31:0] request_size;
    logic [31:0] block_address;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] data_address;
    logic [31:0] block_bytes;
  } rsp_t;

endpackage
`default_nettype wire

@@ src/bfa_ram.sv @@
// ----------------------------------------------------------------------------
// bfa_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none
module bfa_ram #(
  parameter int unsigned WIDTH = 65,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

@@ src/best_fit_block_allocator_top.sv @@
// ----------------------------------------------------------------------------
// best_fit_block_allocator_top
// Best-fit heap allocator over an address-ordered block table, with
// coalescing of free neighbours on free.
// ----------------------------------------------------------------------------
// One transaction at a time. The table sits in one RAM with a registered
// read port, walked by a small sequencer one entry per cycle. An allocate
// scans the table, then writes; a free does the lookup and neighbour reads,
// plus a bound check, a read and a write per entry moved down on each merge.
// The RAM read port sets the pace. No clearing pass is needed after reset.
`default_nettype none
module best_fit_block_allocator_top #(
  parameter int unsigned MAX_BLOCKS   = bfa_pkg::MaxBlocksDefault,
  parameter int unsigned HEADER_BYTES = bfa_pkg::HeaderBytesDefault
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire bfa_pkg::req_t  in_data,
  output logic                out_valid,
  input  wire logic           out_ready,
  output bfa_pkg::rsp_t       out_data,
  input  wire logic           psel,
  input  wire logic           penable,
  input  wire logic           pwrite,
  input  wire logic [1:0]     paddr,
  input  wire logic [31:0]    pwdata,
  output logic      [31:0]    prdata,
  output logic                pready
);

  localparam int unsigned IW = $clog2(MAX_BLOCKS);
  localparam int unsigned CW = $clog2(MAX_BLOCKS + 1);
  localparam int unsigned EW = $bits(bfa_pkg::entry_t);
  localparam logic [32:0] Hdr = 33'(HEADER_BYTES);
  localparam logic [1:0]  RegHeapLimit = 2'd0;

  typedef enum logic [12:0] {
    S_IDLE   = 13'b0000000000001,
    S_SCAN   = 13'b0000000000010,
    S_AWRITE = 13'b0000000000100,
    S_FSCAN  = 13'b0000000001000,
    S_FPREV  = 13'b0000000010000,
    S_FNEXT  = 13'b0000000100000,
    S_FMERGE = 13'b0000001000000,
    S_SHRD   = 13'b0000010000000,
    S_SHWR   = 13'b0000100000000,
    S_FCHK   = 13'b0001000000000,
    S_FWAIT  = 13'b0010000000000,
    S_FDONE  = 13'b0100000000000,
    S_OUT    = 13'b1000000000000
  } state_t;

  state_t state;

  logic [31:0] heap_limit;
  logic [31:0] heap_top;
  logic [CW-1:0] entry_count;

  bfa_pkg::req_t req;
  bfa_pkg::rsp_t rsp;
  logic [31:0] need;

  // scan bookkeeping
  logic [CW-1:0] issue;     // next index to read
  logic [CW-1:0] cur;       // index of data arriving this cycle
  logic          rd_live;   // data at the RAM output is for cur
  logic          found;
  logic [IW-1:0] best;
  bfa_pkg::entry_t best_e;

  // free bookkeeping
  logic [IW-1:0] idx;
  bfa_pkg::entry_t cur_e;
  logic [CW-1:0] sh;        // shift position
  logic          prev_phase; // merging with previous (else next)
  logic          phase_step; // 0 read wait, 1 data valid

  // ram port
  logic          we;
  logic [IW-1:0] waddr, raddr;
  bfa_pkg::entry_t wdata, rdata;

  bfa_ram #(.WIDTH(EW), .DEPTH(MAX_BLOCKS)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
    .raddr(raddr), .rdata(rdata)
  );

  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_OUT);
  assign out_data  = rsp;
  assign pready    = 1'b1;
  assign prdata    = (paddr == RegHeapLimit) ? heap_limit : 32'd0;

  // saturating merged size
  function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
    logic [33:0] s;
    s = 34'(a) + 34'(b) + 34'(Hdr);
    return (s > 34'h0_FFFF_FFFF) ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  logic [33:0] new_top;
  assign new_top = 34'(heap_top) + 34'(Hdr) + 34'(need);

  // register write
  always_ff @(posedge clk) begin
    if (rst) begin
      heap_limit <= bfa_pkg::HeapLimitReset;
    end else if (psel && penable && pwrite && paddr == RegHeapLimit) begin
      heap_limit <= pwdata;
    end
  end

  // read address: one entry per cycle from the sequencer
  always_comb begin
    raddr = issue[IW-1:0];
    if (state == S_FPREV) raddr = idx - IW'(1);
    if (state == S_FNEXT || state == S_FCHK) raddr = idx + IW'(1);
    if (state == S_SHRD)  raddr = sh[IW-1:0];
  end

  // write port
  always_comb begin
    we = 1'b0;
    waddr = idx;
    wdata = cur_e;
    unique case (state)
      S_AWRITE: begin
        we = rsp.status == bfa_pkg::StOk;
        waddr = found ? best : entry_count[IW-1:0];
        wdata = found ? bfa_pkg::entry_t'{start: best_e.start, size: best_e.size,
                                          free: 1'b0}
                      : bfa_pkg::entry_t'{start: heap_top, size: need, free: 1'b0};
      end
      S_SHWR: begin
        we = 1'b1;
        waddr = sh[IW-1:0] - IW'(1);
        wdata = rdata;
      end
      S_FDONE: begin
        we = 1'b1;
        waddr = idx;
        wdata = '{start: cur_e.start, size: cur_e.size, free: 1'b1};
      end
      default: ;
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      entry_count <= '0;
      heap_top    <= '0;
    end else begin
      unique case (state)
        S_IDLE: if (in_valid) begin
          req <= in_data;
          rsp <= '0;
          found <= 1'b0;
          best <= '0;
          issue <= '0;
          cur <= '0;
          rd_live <= 1'b0;
          need <= ((in_data.request_size - 32'd1) & ~32'd7) + 32'd8;
          if (in_data.opcode == bfa_pkg::OpAlloc) begin
            if (in_data.request_size == 32'd0) begin
              rsp.status <= bfa_pkg::StZero;
              state <= S_OUT;
            end else if (in_data.request_size > 32'hFFFF_FFF8) begin
              rsp.status <= bfa_pkg::StNoSpace;
              state <= S_OUT;
            end else begin
              state <= S_SCAN;
            end
          end else begin
            if (in_data.block_address == 32'd0) begin
              rsp.status <= bfa_pkg::StNull;
              state <= S_OUT;
            end else begin
              state <= S_FSCAN;
            end
          end
        end
        // best-fit walk, one entry per cycle
        S_SCAN: begin
          if (issue < entry_count) issue <= issue + CW'(1);
          rd_live <= issue < entry_count;
          cur <= issue;
          if (rd_live) begin
            if (rdata.free && rdata.size >= need &&
                (!found || rdata.size < best_e.size)) begin
              found <= 1'b1;
              best <= cur[IW-1:0];
              best_e <= rdata;
            end
          end
          if (!rd_live && issue >= entry_count && (cur != '0 || issue == '0)) begin
            state <= S_AWRITE;
            if (found) begin
              rsp <= '{status: bfa_pkg::StOk,
                       data_address: best_e.start + Hdr[31:0],
                       block_bytes: best_e.size};
            end else if (entry_count >= CW'(MAX_BLOCKS) ||
                         new_top > 34'(heap_limit)) begin
              rsp.status <= bfa_pkg::StNoSpace;
            end else begin
              rsp <= '{status: bfa_pkg::StOk,
                       data_address: heap_top + Hdr[31:0],
                       block_bytes: need};
            end
          end
        end
        S_AWRITE: begin
          if (!found && rsp.status == bfa_pkg::StOk) begin
            entry_count <= entry_count + CW'(1);
            heap_top <= new_top[31:0];
          end
          state <= S_OUT;
        end
        // pointer lookup walk
        S_FSCAN: begin
          if (issue < entry_count) issue <= issue + CW'(1);
          rd_live <= issue < entry_count;
          cur <= issue;
          if (rd_live && !found &&
              34'(rdata.start) + 34'(Hdr) == 34'(req.block_address)) begin
            found <= 1'b1;
            idx <= cur[IW-1:0];
            cur_e <= rdata;
            phase_step <= 1'b0;
            state <= (cur != '0) ? S_FPREV : S_FNEXT;
          end else if (!rd_live && issue >= entry_count &&
                       (cur != '0 || issue == '0)) begin
            rsp.status <= bfa_pkg::StUnknown;
            state <= S_OUT;
          end
        end
        // previous neighbour
        S_FPREV: begin
          phase_step <= ~phase_step;
          if (phase_step) begin
            if (rdata.free) begin
              cur_e <= '{start: rdata.start, size: sat_add(rdata.size, cur_e.size),
                         free: 1'b1};
              prev_phase <= 1'b1;
              sh <= CW'(idx) + CW'(1);
              idx <= idx - IW'(1);
              state <= S_FMERGE;
            end else begin
              state <= S_FNEXT;
            end
          end
        end
        // next neighbour
        S_FNEXT: begin
          phase_step <= ~phase_step;
          if (CW'(idx) + CW'(1) >= entry_count) begin
            state <= S_FDONE;
          end else if (phase_step) begin
            if (rdata.free) begin
              cur_e <= '{start: cur_e.start, size: sat_add(cur_e.size, rdata.size),
                         free: 1'b1};
              prev_phase <= 1'b0;
              sh <= CW'(idx) + CW'(2);
              state <= S_FMERGE;
            end else begin
              state <= S_FDONE;
            end
          end
        end
        // remove entry sh-1 by moving later entries down
        S_FMERGE: begin
          if (sh >= entry_count) begin
            entry_count <= entry_count - CW'(1);
            state <= prev_phase ? S_FCHK : S_FDONE;
            phase_step <= 1'b0;
          end else begin
            state <= S_SHRD;
          end
        end
        S_SHRD: state <= S_SHWR;
        S_SHWR: begin
          sh <= sh + CW'(1);
          state <= S_FMERGE;
        end
        // after a backward merge, check the next neighbour
        S_FCHK: state <= S_FWAIT;
        S_FWAIT: begin
          phase_step <= 1'b0;
          state <= S_FNEXT;
        end
        S_FDONE: begin
          rsp <= '{status: bfa_pkg::StOk, data_address: 32'd0,
                   block_bytes: cur_e.size};
          state <= S_OUT;
        end
        S_OUT: if (out_ready) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

@@ tb/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Drives allocate and free transactions into the best-fit block allocator,
// predicts every response from a local copy of the block table and heap
// top, and compares each response field by field. heap_limit is rewritten
// between phases while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NumBlocks = bfa_pkg::MaxBlocksDefault;
  localparam int unsigned HdrBytes  = bfa_pkg::HeaderBytesDefault;
  localparam int unsigned CycleLimit = 2000000;
  localparam logic [1:0] AddrHeapLimit = 2'd0;

  logic          clk;
  logic          rst;
  logic          in_valid;
  logic          in_ready;
  bfa_pkg::req_t in_data;
  logic          out_valid;
  logic          out_ready;
  bfa_pkg::rsp_t out_data;
  logic          psel;
  logic          penable;
  logic          pwrite;
  logic [1:0]    paddr;
  logic [31:0]   pwdata;
  logic [31:0]   prdata;
  logic          pready;

  best_fit_block_allocator_top u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // predictor state: mirror of the block table
  logic [31:0] blk_start [NumBlocks];
  logic [31:0] blk_size  [NumBlocks];
  logic        blk_free  [NumBlocks];
  int unsigned blk_count;
  logic [31:0] top_of_heap;
  logic [31:0] limit_reg;

  bfa_pkg::rsp_t pending_rsp[$];
  int            fail_count;
  int unsigned   cycle_count = 0;
  logic          calm;

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // cycle counter and timeout
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  task automatic drop_entry(input int unsigned idx);
    for (int unsigned i = idx; i + 1 < blk_count; i++) begin
      blk_start[i] = blk_start[i+1];
      blk_size[i]  = blk_size[i+1];
      blk_free[i]  = blk_free[i+1];
    end
    blk_count--;
  endtask

  function automatic logic [31:0] sat_merge(input logic [31:0] a, input logic [31:0] b);
    logic [33:0] s;
    s = {2'b0, a} + {2'b0, b} + 34'(HdrBytes);
    return (s > 34'hFFFF_FFFF) ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  // predicts the response to one request and updates the table mirror
  task automatic predict_heap(input bfa_pkg::req_t rq, output bfa_pkg::rsp_t rs);
    logic [31:0] need;
    logic [33:0] next_top;
    int unsigned best, idx;
    logic        found;
    best  = 0;
    idx   = 0;
    found = 1'b0;
    rs    = '0;
    if (rq.opcode == bfa_pkg::OpAlloc) begin
      if (rq.request_size == 0) rs.status = bfa_pkg::StZero;
      else if (rq.request_size > 32'hFFFF_FFF8) rs.status = bfa_pkg::StNoSpace;
      else begin
        need = (((rq.request_size - 1) >> 3) << 3) + 8;
        for (int unsigned i = 0; i < blk_count; i++)
          if (blk_free[i] && blk_size[i] >= need)
            if (!found || blk_size[i] < blk_size[best]) begin
              best  = i;
              found = 1'b1;
            end
        if (found) begin
          blk_free[best]  = 1'b0;
          rs.status       = bfa_pkg::StOk;
          rs.data_address = blk_start[best] + HdrBytes;
          rs.block_bytes  = blk_size[best];
        end else begin
          next_top = {2'b0, top_of_heap} + 34'(HdrBytes) + {2'b0, need};
          if (blk_count >= NumBlocks || next_top > {2'b0, limit_reg})
            rs.status = bfa_pkg::StNoSpace;
          else begin
            blk_start[blk_count] = top_of_heap;
            blk_size[blk_count]  = need;
            blk_free[blk_count]  = 1'b0;
            blk_count++;
            rs.status       = bfa_pkg::StOk;
            rs.data_address = top_of_heap + HdrBytes;
            rs.block_bytes  = need;
            top_of_heap     = next_top[31:0];
          end
        end
      end
    end else if (rq.block_address == 0) begin
      rs.status = bfa_pkg::StNull;
    end else begin
      for (int unsigned i = 0; i < blk_count; i++)
        if (!found && {1'b0, blk_start[i]} + 33'(HdrBytes) == {1'b0, rq.block_address})
        begin
          idx   = i;
          found = 1'b1;
        end
      if (!found) rs.status = bfa_pkg::StUnknown;
      else begin
        // merge with free neighbour before, then after
        if (idx > 0 && blk_free[idx-1]) begin
          blk_size[idx-1] = sat_merge(blk_size[idx-1], blk_size[idx]);
          drop_entry(idx);
          idx--;
        end
        if (idx + 1 < blk_count && blk_free[idx+1]) begin
          blk_size[idx] = sat_merge(blk_size[idx], blk_size[idx+1]);
          drop_entry(idx + 1);
        end
        blk_free[idx]  = 1'b1;
        rs.status      = bfa_pkg::StOk;
        rs.block_bytes = blk_size[idx];
      end
    end
  endtask

  // response checker with random stalls
  initial begin
    int stall;
    bfa_pkg::rsp_t want;
    out_ready = 1'b0;
    stall = 0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) begin
        if (pending_rsp.size() == 0) begin
          report_mismatch("unexpected response", out_data.block_bytes, 32'd0);
        end else begin
          want = pending_rsp.pop_front();
          if (out_data.status !== want.status)
            report_mismatch("status", 32'(out_data.status), 32'(want.status));
          if (out_data.data_address !== want.data_address)
            report_mismatch("data_address", out_data.data_address, want.data_address);
          if (out_data.block_bytes !== want.block_bytes)
            report_mismatch("block_bytes", out_data.block_bytes, want.block_bytes);
        end
      end
      if (stall > 0) stall--;
      else if (!calm && $urandom_range(0, 5) == 0) stall = $urandom_range(1, 3);
      out_ready <= (stall == 0);
    end
  end

  // APB write: setup then access
  task automatic write_heap_limit(input logic [31:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= AddrHeapLimit;
    pwdata  <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    limit_reg = v;
  endtask

  // one request transaction with an optional gap before it
  task automatic send_request(input bfa_pkg::req_t rq, input logic check_now,
                              input bfa_pkg::rsp_t fixed);
    bfa_pkg::rsp_t want;
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    predict_heap(rq, want);
    // directed rows are held to the typed-in response, the rest to the predictor
    pending_rsp.push_back(check_now ? fixed : want);
    in_valid <= 1'b1;
    in_data  <= rq;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (3 * NumBlocks + 20) @(posedge clk);
  endtask

  function automatic bfa_pkg::req_t mk(input logic op, input logic [31:0] sz,
                                       input logic [31:0] ad);
    bfa_pkg::req_t r;
    r.opcode = op;
    r.request_size = sz;
    r.block_address = ad;
    return r;
  endfunction

  function automatic bfa_pkg::rsp_t rs3(input logic [2:0] st, input logic [31:0] da,
                                        input logic [31:0] bb);
    bfa_pkg::rsp_t r;
    r.status = st;
    r.data_address = da;
    r.block_bytes = bb;
    return r;
  endfunction

  // random address: mostly a live data address, sometimes noise
  function automatic logic [31:0] pick_address();
    if (blk_count != 0 && $urandom_range(0, 9) < 8)
      return blk_start[$urandom_range(0, blk_count - 1)] + HdrBytes;
    case ($urandom_range(0, 3))
      0: return 32'd0;
      1: return top_of_heap + HdrBytes;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [31:0] pick_size();
    case ($urandom_range(0, 19))
      0: return 32'd0;
      1: return $urandom_range(32'hFFFF_FFF0, 32'hFFFF_FFFF);
      2: return $urandom();
      default: return $urandom_range(1, 200);
    endcase
  endfunction

  typedef struct {
    bfa_pkg::req_t rq;
    logic          check_now;
    bfa_pkg::rsp_t fixed;
  } stim_row_t;

  // directed stimulus from reset, heap_limit at reset value
  stim_row_t directed [] = '{
    '{mk(bfa_pkg::OpAlloc, 32'd0, 32'd0),         1'b1, rs3(bfa_pkg::StZero, 0, 0)},
    '{mk(bfa_pkg::OpAlloc, 32'hFFFF_FFF9, 32'd0), 1'b1, rs3(bfa_pkg::StNoSpace, 0, 0)},
    '{mk(bfa_pkg::OpAlloc, 32'hFFFF_FFFF, 32'd0), 1'b1, rs3(bfa_pkg::StNoSpace, 0, 0)},
    '{mk(bfa_pkg::OpFree, 32'd0, 32'd0),          1'b1, rs3(bfa_pkg::StNull, 0, 0)},
    '{mk(bfa_pkg::OpFree, 32'd0, 32'd32),         1'b1, rs3(bfa_pkg::StUnknown, 0, 0)},
    '{mk(bfa_pkg::OpAlloc, 32'd1, 32'hFFFF_FFFF), 1'b1,
      rs3(bfa_pkg::StOk, 32'd32, 32'd8)},
    '{mk(bfa_pkg::OpAlloc, 32'd24, 32'd0),        1'b1,
      rs3(bfa_pkg::StOk, 32'd72, 32'd24)},
    '{mk(bfa_pkg::OpAlloc, 32'd9, 32'd0),         1'b1,
      rs3(bfa_pkg::StOk, 32'd128, 32'd16)},
    '{mk(bfa_pkg::OpAlloc, 32'd8, 32'd0),         1'b0, '0},
    '{mk(bfa_pkg::OpFree, 32'd0, 32'd72),         1'b1, rs3(bfa_pkg::StOk, 0, 32'd24)},
    '{mk(bfa_pkg::OpFree, 32'd0, 32'd72),         1'b1, rs3(bfa_pkg::StOk, 0, 32'd24)},
    '{mk(bfa_pkg::OpAlloc, 32'd5, 32'd0),         1'b1,
      rs3(bfa_pkg::StOk, 32'd72, 32'd24)},
    '{mk(bfa_pkg::OpFree, 32'd0, 32'd72),         1'b0, '0},
    '{mk(bfa_pkg::OpFree, 32'd0, 32'd32),         1'b1, rs3(bfa_pkg::StOk, 0, 32'd64)},
    '{mk(bfa_pkg::OpFree, 32'd0, 32'd128),        1'b0, '0},
    '{mk(bfa_pkg::OpFree, 32'd0, 32'd72),         1'b1, rs3(bfa_pkg::StUnknown, 0, 0)},
    '{mk(bfa_pkg::OpAlloc, 32'd100, 32'd0),       1'b0, '0},
    '{mk(bfa_pkg::OpFree, 32'd0, 32'hFFFF_FFFF),  1'b1, rs3(bfa_pkg::StUnknown, 0, 0)},
    '{mk(bfa_pkg::OpAlloc, 32'hFFFF_FFF8, 32'd0), 1'b0, '0}
  };

  initial begin
    bfa_pkg::req_t rq;
    logic [31:0] limits [5];
    in_valid = 1'b0;
    in_data  = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    fail_count = 0;
    calm = 1'b0;
    blk_count = 0;
    top_of_heap = '0;
    limit_reg = bfa_pkg::HeapLimitReset;
    rst = 1'b1;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed[i]) send_request(directed[i].rq, directed[i].check_now,
                                       directed[i].fixed);
    wait_idle();

    // random phases over several limits, extremes included
    limits = '{32'd0, 32'd2000, 32'd600, 32'hFFFF_FFFF, 32'd5000};
    for (int ph = 0; ph < 5; ph++) begin
      write_heap_limit(limits[ph]);
      if (ph == 4) calm = 1'b1;
      for (int n = 0; n < 100; n++) begin
        rq.opcode = 1'($urandom_range(0, 1));
        rq.request_size = pick_size();
        rq.block_address = pick_address();
        send_request(rq, 1'b0, '0);
      end
      wait_idle();
    end

    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
`default_nettype wire
